/* hdl/assert_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros shared by the RTL. Each expects i_clk and i_rst_n in scope.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The condition must hold at every clock edge outside of reset.
`define CHK_ALWAYS(lbl, cond, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) \
        else $error(msg);

// When the antecedent holds, the consequent must hold in the same cycle.
`define CHK_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// When the antecedent holds, the consequent must hold in the cycle after.
`define CHK_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hdl/dcaos_pkg.sv */
// ----------------------------------------------------------------------------
// dcaos_pkg
// Types and constants for the two-channel ADC oversampling sequencer.
// ----------------------------------------------------------------------------
package dcaos_pkg;

    localparam int SAMPLE_W      = 10;
    localparam int COUNT_W       = 6;
    localparam int VALUE_W       = 14;
    localparam int CFG_IDX_W     = 2;
    localparam int ACCUM_BITS_DEF = 16;

    localparam logic [COUNT_W-1:0] CONV_RESET   = 6'd16;
    localparam logic [COUNT_W-1:0] WINDOW_RESET = 6'd25;

    localparam logic [1:0] MUX_INPUT_ONE = 2'd1;
    localparam logic [1:0] MUX_INPUT_TWO = 2'd2;

    typedef enum logic {
        OP_TICK   = 1'b0,
        OP_SAMPLE = 1'b1
    } t_op;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_CONVERSIONS = 2'd0,
        CFG_WINDOW      = 2'd1
    } t_cfg_idx;

    typedef struct packed {
        t_op                 op;
        logic [SAMPLE_W-1:0] sample;
    } t_in_word;

    typedef struct packed {
        logic                start_conversion;
        logic [1:0]          mux_channel;
        logic                pair_valid;
        logic [VALUE_W-1:0]  first_value;
        logic [VALUE_W-1:0]  second_value;
    } t_out_word;

endpackage

/* hdl/dual_channel_adc_oversample_sequencer.sv */
// ----------------------------------------------------------------------------
// dual_channel_adc_oversample_sequencer
// Paces conversions of a two-sensor ADC and accumulates samples into two
// oversampling sums that are delivered as a pair of averaged values.
// ----------------------------------------------------------------------------
//  Channel   Direction  Handshake               Word
//  in        sink       i_in_valid / o_in_stall  op, sample
//  out       source     o_out_valid / i_out_stall start, mux, pair, two values
//  cfg       sink       i_cfg_valid / o_cfg_ready index, 6-bit data
//
// A new word can be accepted every clock while o_in_stall is low.
// The result goes into an output register; a one-entry skid register lets the
// block take one more word while the output is stalled, after which o_in_stall
// rises until the skid entry drains. The synchronous active-low reset clears
// the counter, the select bits, both sums and both valid flags, and sets the
// configuration registers to their defaults.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module dual_channel_adc_oversample_sequencer #(
    parameter int ACCUM_BITS = dcaos_pkg::ACCUM_BITS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  dcaos_pkg::t_in_word                 i_in_word,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output dcaos_pkg::t_out_word                o_out_word,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [dcaos_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [dcaos_pkg::COUNT_W-1:0]       i_cfg_data
);
    import dcaos_pkg::*;

    // Configuration registers.
    logic [COUNT_W-1:0]     r_conv;
    logic [COUNT_W-1:0]     r_window;

    // Sequencer state.
    logic [COUNT_W-1:0]     r_count;
    logic                   r_sel;
    logic                   r_chan_one;
    logic [ACCUM_BITS-1:0]  r_sums [2];

    // Output register and skid entry.
    logic                   r_out_valid;
    t_out_word              r_out;
    logic                   r_skid_valid;
    t_out_word              r_skid;

    // Next-state values.
    logic [COUNT_W-1:0]     n_count;
    logic                   n_sel;
    logic                   n_chan_one;
    logic [ACCUM_BITS-1:0]  n_sums [2];
    t_out_word              n_word;

    logic                   accept;
    logic                   out_take;
    logic [COUNT_W-1:0]     count_inc;
    logic                   tick_start;
    logic                   tick_toggle;
    logic                   tick_deliver;
    logic                   tick_restart;
    logic [ACCUM_BITS+VALUE_W-1:0] ext_first;
    logic [ACCUM_BITS+VALUE_W-1:0] ext_second;

    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = r_skid_valid;
    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out;

    assign accept   = i_in_valid && !o_in_stall;
    assign out_take = r_out_valid && !i_out_stall;

    // Tick decode. The toggle point is compared one bit wider so that a
    // conversion count of 63 gives a point of 64 that the counter never hits.
    assign count_inc    = r_count + COUNT_W'(1);
    assign tick_start   = (count_inc <= r_conv);
    assign tick_toggle  = ({1'b0, count_inc} == ({1'b0, r_conv} + (COUNT_W+1)'(1)));
    assign tick_deliver = tick_toggle && r_sel;
    assign tick_restart = (count_inc == r_window);

    // Averaged values are the sums shifted right by two, fitted to 14 bits.
    assign ext_first  = {{VALUE_W{1'b0}}, r_sums[0]};
    assign ext_second = {{VALUE_W{1'b0}}, r_sums[1]};

    always_comb begin
        n_count    = r_count;
        n_sel      = r_sel;
        n_chan_one = r_chan_one;
        n_sums[0]  = r_sums[0];
        n_sums[1]  = r_sums[1];
        n_word     = '0;

        case (i_in_word.op)
            OP_SAMPLE: begin
                // Samples wrap inside the selected accumulator.
                n_sums[r_sel] = r_sums[r_sel]
                                + ACCUM_BITS'(i_in_word.sample);
            end
            OP_TICK: begin
                n_count                = count_inc;
                n_word.start_conversion = tick_start;
                if (tick_deliver) begin
                    n_word.pair_valid   = 1'b1;
                    n_word.first_value  = ext_first[VALUE_W+1:2];
                    n_word.second_value = ext_second[VALUE_W+1:2];
                    n_sums[0]           = '0;
                    n_sums[1]           = '0;
                end
                if (tick_toggle) begin
                    n_sel = !r_sel;
                end
                // The restart follows the toggle when both fall on one tick.
                if (tick_restart) begin
                    n_count    = '0;
                    n_chan_one = !r_chan_one;
                end
            end
            default: begin
                n_count = r_count;
            end
        endcase

        n_word.mux_channel = n_chan_one ? MUX_INPUT_ONE : MUX_INPUT_TWO;
    end

    // Configuration writes; indexes outside the register list are ignored.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_conv   <= CONV_RESET;
            r_window <= WINDOW_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_CONVERSIONS: r_conv   <= i_cfg_data;
                CFG_WINDOW:      r_window <= i_cfg_data;
                default:         r_conv   <= r_conv;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count    <= '0;
            r_sel      <= 1'b0;
            r_chan_one <= 1'b0;
            r_sums[0]  <= '0;
            r_sums[1]  <= '0;
        end else if (accept) begin
            r_count    <= n_count;
            r_sel      <= n_sel;
            r_chan_one <= n_chan_one;
            r_sums[0]  <= n_sums[0];
            r_sums[1]  <= n_sums[1];
        end
    end

    // Output register with a one-entry skid behind it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            if (out_take) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end
        end else if (accept) begin
            r_out_valid <= 1'b1;
            if (r_out_valid && !out_take) begin
                r_skid_valid <= 1'b1;
            end
        end else if (out_take) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_valid) begin
            if (out_take) begin
                r_out <= r_skid;
            end
        end else if (accept) begin
            if (!r_out_valid || out_take) begin
                r_out <= n_word;
            end else begin
                r_skid <= n_word;
            end
        end
    end

    `CHK_SAME(a_skid_needs_out, r_skid_valid, r_out_valid, "skid entry without output entry")
    `CHK_NEXT(a_deliver_clears, accept && i_in_word.op == OP_TICK && tick_deliver,
              r_sums[0] == '0 && r_sums[1] == '0, "sums not cleared after delivery")
    `CHK_SAME(a_pair_no_start, r_out_valid && r_out.pair_valid, !r_out.start_conversion,
              "pair delivered on a conversion tick")
    `CHK_SAME(a_values_need_pair, r_out_valid && !r_out.pair_valid,
              r_out.first_value == '0 && r_out.second_value == '0,
              "values present without a pair")
    `CHK_NEXT(a_stall_fills_skid, accept && r_out_valid && i_out_stall, r_skid_valid,
              "word lost while output stalled")

endmodule
